// ===== hw/rtl/v2s_pkg.sv =====
`default_nettype none
package v2s_pkg;

	// field widths
	localparam int VW    = 20;             // velocity word
	localparam int STW   = 19;             // steering angle
	localparam int RADW  = 31;             // turn radius
	localparam int ZW    = 20;             // CORDIC angle accumulator
	localparam int DVW   = 36;             // divider dividend |vx| << 16
	localparam int SQW   = 64;             // root operand
	localparam int ROOTW = 32;
	localparam int REMW  = 34;
	localparam int NW    = 41;             // normalized atan operands
	localparam int CXW   = 44;             // CORDIC x/y
	localparam int DW    = 35;             // 2*X - T

	localparam int DIV_STEPS    = 36;
	localparam int SQRT_STEPS   = 32;
	localparam int NORM_STEPS   = 6;
	localparam int CORDIC_STEPS = 17;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 96;
	localparam int OUT_TUSER_W = 4;
	localparam int CFGW        = 20;
	localparam int CFG_AW      = 3;

	localparam bit SIDE_SLIP_DEFAULT = 1'b1;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_ZERO_BAND    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_TRACK_WIDTH  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_AXLE_SPACING = 3'd2;
	localparam logic [CFG_AW-1:0] REG_MIN_RADIUS   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_MAX_SPEED    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_MAX_YAW      = 3'd5;
	localparam logic [CFG_AW-1:0] REG_MAX_CRAB     = 3'd6;
	localparam logic [CFG_AW-1:0] REG_MAX_ACK      = 3'd7;

	localparam logic [16:0] RST_ZERO_BAND = 17'd66;
	localparam logic [19:0] RST_TRACK     = 20'd26214;
	localparam logic [19:0] RST_AXLE      = 20'd32768;
	localparam logic [19:0] RST_MIN_RAD   = 20'd32768;
	localparam logic [19:0] RST_MAX_SPEED = 20'd98304;
	localparam logic [19:0] RST_MAX_YAW   = 20'd65536;
	localparam logic [17:0] RST_MAX_CRAB  = 18'd45747;
	localparam logic [17:0] RST_MAX_ACK   = 18'd45747;

	// motion mode codes
	localparam logic [1:0] MODE_ACK  = 2'd0;
	localparam logic [1:0] MODE_SLIP = 2'd1;
	localparam logic [1:0] MODE_PAR  = 2'd2;
	localparam logic [1:0] MODE_SPIN = 2'd3;

	typedef enum logic [2:0] {
		K_STOP,
		K_SLIP,
		K_CRAB_Y,
		K_PAR,
		K_STRAIGHT,
		K_CURVE
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic signed [VW-1:0]   vx;
		logic signed [VW-1:0]   vy;
		logic signed [VW-1:0]   wz;
		logic [RADW-1:0]        radius;
		logic [VW-1:0]          speed;
		logic                   bad;
		logic                   azero;
	} ctx_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = ZW'(51472);
			1:  r = ZW'(30385);
			2:  r = ZW'(16055);
			3:  r = ZW'(8150);
			4:  r = ZW'(4091);
			5:  r = ZW'(2047);
			6:  r = ZW'(1024);
			7:  r = ZW'(512);
			8:  r = ZW'(256);
			9:  r = ZW'(128);
			10: r = ZW'(64);
			11: r = ZW'(32);
			12: r = ZW'(16);
			13: r = ZW'(8);
			14: r = ZW'(4);
			15: r = ZW'(2);
			16: r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
		return v[VW-1] ? VW'(-v) : VW'(v);
	endfunction

	function automatic logic signed [23:0] clamp_mag(input logic signed [23:0] v,
			input logic [VW-1:0] lim);
		logic signed [23:0] m;
		m = $signed({4'b0, lim});
		if (v > m)
			return m;
		else if (v < -m)
			return -m;
		return v;
	endfunction

	function automatic logic [VW-1:0] sat20(input logic signed [23:0] v);
		if (v > 24'sd524287)
			return 20'h7FFFF;
		else if (v < -24'sd524288)
			return 20'h80000;
		return v[VW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/v2s_div_cell.sv =====
`default_nettype none
module v2s_div_cell (
	input  wire                        clk,
	input  wire                        en,
	input  wire [v2s_pkg::DVW-1:0]     dvd_i,
	input  wire [v2s_pkg::VW-1:0]      rem_i,
	input  wire [v2s_pkg::VW-1:0]      dsr_i,
	output logic [v2s_pkg::DVW-1:0]    dvd_o,
	output logic [v2s_pkg::VW-1:0]     rem_o,
	output logic [v2s_pkg::VW-1:0]     dsr_o
);
	import v2s_pkg::*;

	logic [VW:0] rem_sh;
	logic [VW:0] rem_sub;
	logic        ge;

	// one restoring step: quotient bit enters at the bottom of the dividend
	assign rem_sh  = {rem_i, dvd_i[DVW-1]};
	assign ge      = rem_sh >= {1'b0, dsr_i};
	assign rem_sub = rem_sh - {1'b0, dsr_i};

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_o <= {dvd_i[DVW-2:0], ge};
			rem_o <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
			dsr_o <= dsr_i;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/v2s_sqrt_cell.sv =====
`default_nettype none
module v2s_sqrt_cell (
	input  wire                          clk,
	input  wire                          en,
	input  wire [v2s_pkg::SQW-1:0]       n_i,
	input  wire [v2s_pkg::REMW-1:0]      rem_i,
	input  wire [v2s_pkg::ROOTW-1:0]     root_i,
	output logic [v2s_pkg::SQW-1:0]      n_o,
	output logic [v2s_pkg::REMW-1:0]     rem_o,
	output logic [v2s_pkg::ROOTW-1:0]    root_o
);
	import v2s_pkg::*;

	logic [REMW+1:0] rem_sh;
	logic [REMW+1:0] trial;
	logic            ge;

	// one root digit per cell, two operand bits taken from the top
	assign rem_sh = {rem_i, n_i[SQW-1:SQW-2]};
	assign trial  = {2'b0, root_i, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			n_o    <= {n_i[SQW-3:0], 2'b00};
			rem_o  <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
			root_o <= {root_i[ROOTW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/v2s_norm_cell.sv =====
`default_nettype none
module v2s_norm_cell #(
	parameter int SHIFT = 1
) (
	input  wire                        clk,
	input  wire                        en,
	input  wire [v2s_pkg::NW-1:0]      a_i,
	input  wire [v2s_pkg::NW-1:0]      b_i,
	output logic [v2s_pkg::NW-1:0]     a_o,
	output logic [v2s_pkg::NW-1:0]     b_o
);
	import v2s_pkg::*;

	logic [NW-1:0] ab;
	logic          sh;

	// shift both while the pair still fits below the top bit
	assign ab = a_i | b_i;
	assign sh = (ab >> (NW - SHIFT)) == '0;

	always_ff @(posedge clk) begin
		if (en) begin
			a_o <= sh ? (a_i << SHIFT) : a_i;
			b_o <= sh ? (b_i << SHIFT) : b_i;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/v2s_cordic_cell.sv =====
`default_nettype none
module v2s_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire                               clk,
	input  wire                               en,
	input  wire signed [v2s_pkg::CXW-1:0]     x_i,
	input  wire signed [v2s_pkg::CXW-1:0]     y_i,
	input  wire signed [v2s_pkg::ZW-1:0]      z_i,
	output logic signed [v2s_pkg::CXW-1:0]    x_o,
	output logic signed [v2s_pkg::CXW-1:0]    y_o,
	output logic signed [v2s_pkg::ZW-1:0]     z_o
);
	import v2s_pkg::*;

	logic signed [CXW-1:0] dx;
	logic signed [CXW-1:0] dy;

	assign dx = y_i >>> IDX;
	assign dy = x_i >>> IDX;

	// vectoring: drive y toward zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[CXW-1]) begin
				x_o <= x_i + dx;
				y_o <= y_i - dy;
				z_o <= z_i + atan_step(IDX);
			end else begin
				x_o <= x_i - dx;
				y_o <= y_i + dy;
				z_o <= z_i - atan_step(IDX);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/velocity_to_steer_mode_command.sv =====
`default_nettype none
// Channel    Dir  Fields (lowest bit first)
// s_axis     in   tdata: forward_speed[19:0] lateral_speed[39:20] yaw_rate[59:40]
// m_axis     out  tdata: linear_cmd steering_cmd angular_cmd curve_radius
//                 tuser: valid_res stop drive_mode
// cfg        in   cfg_we / cfg_addr / cfg_data, write only
//
// One word accepted per clock when the output is free or being taken.
// From the accepting edge to m_tvalid a word passes a front register,
// a 36-cell divider, a square stage, a 32-cell square root, a prep stage,
// a 6-cell normalizer, a 17-cell CORDIC chain and the output register.
// arst_n clears all valid bits and loads register reset values.
// A stalled output stalls the whole chain; no word is dropped.
module velocity_to_steer_mode_command #(
	parameter bit SIDE_SLIP_ENABLE = v2s_pkg::SIDE_SLIP_DEFAULT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// forward_speed, lateral_speed, yaw_rate, zero pad
	input  wire [v2s_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// linear_cmd, steering_cmd, angular_cmd, curve_radius, zero pad
	output logic [v2s_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// valid_res, stop, drive_mode
	output logic [v2s_pkg::OUT_TUSER_W-1:0]    m_tuser,
	input  wire                                cfg_we,
	input  wire [v2s_pkg::CFG_AW-1:0]          cfg_addr,
	input  wire [v2s_pkg::CFGW-1:0]            cfg_data
);
	import v2s_pkg::*;

	localparam int ST_SQ   = DIV_STEPS + 1;
	localparam int ST_PREP = ST_SQ + SQRT_STEPS + 1;
	localparam int ST_LAST = ST_PREP + NORM_STEPS + CORDIC_STEPS;
	localparam int NST     = ST_LAST + 1;

	// ---------------- configuration ----------------
	logic [16:0] band_q;
	logic [19:0] track_q, axle_q, rmin_q, vmax_q, wmax_q;
	logic [17:0] crab_q, ack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q  <= RST_ZERO_BAND;
			track_q <= RST_TRACK;
			axle_q  <= RST_AXLE;
			rmin_q  <= RST_MIN_RAD;
			vmax_q  <= RST_MAX_SPEED;
			wmax_q  <= RST_MAX_YAW;
			crab_q  <= RST_MAX_CRAB;
			ack_q   <= RST_MAX_ACK;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ZERO_BAND:    band_q  <= cfg_data[16:0];
				REG_TRACK_WIDTH:  track_q <= cfg_data;
				REG_AXLE_SPACING: axle_q  <= cfg_data;
				REG_MIN_RADIUS:   rmin_q  <= cfg_data;
				REG_MAX_SPEED:    vmax_q  <= cfg_data;
				REG_MAX_YAW:      wmax_q  <= cfg_data;
				REG_MAX_CRAB:     crab_q  <= cfg_data[17:0];
				REG_MAX_ACK:      ack_q   <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic o_v_q;
	logic adv;
	logic v_q [NST];
	ctx_t ctx_q [NST];

	assign adv      = !o_v_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++)
				v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= s_tvalid;
			for (int i = 1; i < NST; i++)
				v_q[i] <= v_q[i-1];
		end
	end

	// ---------------- front: case decode ----------------
	logic signed [VW-1:0] in_vx, in_vy, in_wz;
	logic [VW-1:0]        in_ax, in_ay, in_aw;
	logic                 zx, zy, zw;
	ctx_t                 ctx_in;
	logic [DVW-1:0]       dvd0_q;
	logic [VW-1:0]        dsr0_q;

	assign in_vx = s_tdata[19:0];
	assign in_vy = s_tdata[39:20];
	assign in_wz = s_tdata[59:40];
	assign in_ax = mag(in_vx);
	assign in_ay = mag(in_vy);
	assign in_aw = mag(in_wz);
	assign zx    = in_ax <= {3'b0, band_q};
	assign zy    = in_ay <= {3'b0, band_q};
	assign zw    = in_aw <= {3'b0, band_q};

	always_comb begin
		ctx_in        = '0;
		ctx_in.vx     = in_vx;
		ctx_in.vy     = in_vy;
		ctx_in.wz     = in_wz;
		if (zx && zy && zw)
			ctx_in.kind = K_STOP;
		else if (!zy) begin
			if (zx && SIDE_SLIP_ENABLE)
				ctx_in.kind = K_SLIP;
			else if (zx)
				ctx_in.kind = K_CRAB_Y;
			else
				ctx_in.kind = K_PAR;
		end else if (zw)
			ctx_in.kind = K_STRAIGHT;
		else
			ctx_in.kind = K_CURVE;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd0_q <= {in_ax, 16'b0};
			dsr0_q <= in_aw;
		end
	end

	// ---------------- divider chain: R = (|vx| << 16) / |wz| ----------------
	logic [DVW-1:0] div_dvd [DIV_STEPS+1];
	logic [VW-1:0]  div_rem [DIV_STEPS+1];
	logic [VW-1:0]  div_dsr [DIV_STEPS+1];

	assign div_dvd[0] = dvd0_q;
	assign div_rem[0] = '0;
	assign div_dsr[0] = dsr0_q;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		v2s_div_cell u_cell (
			.clk   (clk),
			.en    (adv),
			.dvd_i (div_dvd[k]),
			.rem_i (div_rem[k]),
			.dsr_i (div_dsr[k]),
			.dvd_o (div_dvd[k+1]),
			.rem_o (div_rem[k+1]),
			.dsr_o (div_dsr[k+1])
		);
	end

	// ---------------- square stage: root operand ----------------
	ctx_t                 ctx_sq;
	logic [RADW-1:0]      r_sat;
	logic [RADW-1:0]      m_a;
	logic [2*RADW-1:0]    p_a;
	logic [2*VW-1:0]      p_b;
	logic [2*VW-1:0]      p_ay;
	logic [2*VW-1:0]      p_l;
	logic [SQW-1:0]       sq_n0_q;

	assign r_sat = (div_dvd[DIV_STEPS][DVW-1:RADW] != '0) ? '1
	             : div_dvd[DIV_STEPS][RADW-1:0];

	always_comb begin
		ctx_sq        = ctx_q[ST_SQ-1];
		ctx_sq.radius = r_sat;
	end

	assign m_a  = (ctx_q[ST_SQ-1].kind == K_PAR) ? RADW'(mag(ctx_q[ST_SQ-1].vx)) : r_sat;
	assign p_a  = m_a * m_a;
	assign p_ay = mag(ctx_q[ST_SQ-1].vy) * mag(ctx_q[ST_SQ-1].vy);
	assign p_l  = axle_q * axle_q;
	assign p_b  = (ctx_q[ST_SQ-1].kind == K_PAR) ? p_ay : (p_l >> 2);

	always_ff @(posedge clk) begin
		if (adv)
			sq_n0_q <= SQW'(p_a) + SQW'(p_b);
	end

	// ---------------- square root chain ----------------
	logic [SQW-1:0]   sq_n    [SQRT_STEPS+1];
	logic [REMW-1:0]  sq_rem  [SQRT_STEPS+1];
	logic [ROOTW-1:0] sq_root [SQRT_STEPS+1];

	assign sq_n[0]    = sq_n0_q;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		v2s_sqrt_cell u_cell (
			.clk    (clk),
			.en     (adv),
			.n_i    (sq_n[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.n_o    (sq_n[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1])
		);
	end

	// ---------------- prep: D = 2X - T, atan operands ----------------
	ctx_t                 ctx_prep;
	logic signed [DW-1:0] d_val;
	logic                 d_bad;
	logic [NW-1:0]        pa_v, pb_v;
	logic [NW-1:0]        na0_q, nb0_q;

	assign d_val = $signed({2'b0, sq_root[SQRT_STEPS], 1'b0}) - $signed({15'b0, track_q});
	assign d_bad = d_val[DW-1] || (d_val == '0);

	always_comb begin
		ctx_prep       = ctx_q[ST_PREP-1];
		ctx_prep.speed = sq_root[SQRT_STEPS][VW-1:0];
		ctx_prep.bad   = d_bad;
		if (ctx_q[ST_PREP-1].kind == K_PAR) begin
			pa_v = NW'(mag(ctx_q[ST_PREP-1].vy));
			pb_v = NW'(mag(ctx_q[ST_PREP-1].vx));
		end else begin
			pa_v = NW'(axle_q);
			pb_v = d_bad ? NW'(1) : {6'b0, d_val};
		end
		ctx_prep.azero = (pa_v == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na0_q <= pa_v;
			nb0_q <= pb_v;
		end
	end

	// context rides along; square and prep stages load their updated copies
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_q[0] <= ctx_in;
			for (int i = 1; i < NST; i++) begin
				if (i == ST_SQ)
					ctx_q[i] <= ctx_sq;
				else if (i == ST_PREP)
					ctx_q[i] <= ctx_prep;
				else
					ctx_q[i] <= ctx_q[i-1];
			end
		end
	end

	// ---------------- normalizer chain: shifts 32,16,8,4,2,1 ----------------
	logic [NW-1:0] nm_a [NORM_STEPS+1];
	logic [NW-1:0] nm_b [NORM_STEPS+1];

	assign nm_a[0] = na0_q;
	assign nm_b[0] = nb0_q;

	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		v2s_norm_cell #(.SHIFT(1 << (NORM_STEPS - 1 - k))) u_cell (
			.clk (clk),
			.en  (adv),
			.a_i (nm_a[k]),
			.b_i (nm_b[k]),
			.a_o (nm_a[k+1]),
			.b_o (nm_b[k+1])
		);
	end

	// ---------------- CORDIC chain ----------------
	logic signed [CXW-1:0] cx [CORDIC_STEPS+1];
	logic signed [CXW-1:0] cy [CORDIC_STEPS+1];
	logic signed [ZW-1:0]  cz [CORDIC_STEPS+1];

	assign cx[0] = $signed({3'b0, nm_b[NORM_STEPS]});
	assign cy[0] = $signed({3'b0, nm_a[NORM_STEPS]});
	assign cz[0] = '0;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		v2s_cordic_cell #(.IDX(k)) u_cell (
			.clk (clk),
			.en  (adv),
			.x_i (cx[k]),
			.y_i (cy[k]),
			.z_i (cz[k]),
			.x_o (cx[k+1]),
			.y_o (cy[k+1]),
			.z_o (cz[k+1])
		);
	end

	// ---------------- result assembly ----------------
	ctx_t               fc;
	logic signed [23:0] ang_z, sp_s, lin_c, ang_c, st_c;
	logic               f_valid, f_stop;
	logic [1:0]         f_mode;
	logic [RADW-1:0]    f_rad;
	logic               neg_ack;

	assign fc      = ctx_q[ST_LAST];
	assign ang_z   = fc.azero ? '0 : 24'(cz[CORDIC_STEPS]);
	assign sp_s    = fc.vx[VW-1] ? -$signed({4'b0, fc.speed}) : $signed({4'b0, fc.speed});
	assign neg_ack = (fc.vx[VW-1] != fc.wz[VW-1]) && (fc.vx != '0) && (fc.radius != '0);

	always_comb begin
		f_valid = 1'b1;
		f_stop  = 1'b0;
		f_mode  = MODE_ACK;
		f_rad   = '0;
		lin_c   = '0;
		ang_c   = '0;
		st_c    = '0;
		unique case (fc.kind)
			K_STOP: f_stop = 1'b1;
			K_SLIP: begin
				f_mode = MODE_SLIP;
				ang_c  = clamp_mag(24'(fc.vy), vmax_q);
			end
			K_CRAB_Y: begin
				f_mode = MODE_PAR;
				st_c   = fc.vy[VW-1] ? -$signed({6'b0, crab_q}) : $signed({6'b0, crab_q});
				lin_c  = clamp_mag(24'(fc.vy), vmax_q);
			end
			K_PAR: begin
				f_mode = MODE_PAR;
				st_c   = clamp_mag((fc.vx[VW-1] != fc.vy[VW-1]) ? -ang_z : ang_z,
				                   {2'b0, crab_q});
				lin_c  = clamp_mag(sp_s, vmax_q);
			end
			K_STRAIGHT: lin_c = clamp_mag(24'(fc.vx), vmax_q);
			K_CURVE: begin
				f_rad = fc.radius;
				if (fc.radius < RADW'(rmin_q)) begin
					f_mode = MODE_SPIN;
					ang_c  = clamp_mag(24'(fc.wz), wmax_q);
				end else if (fc.bad) begin
					f_valid = 1'b0;
				end else begin
					lin_c = clamp_mag(24'(fc.vx), vmax_q);
					st_c  = clamp_mag(neg_ack ? -ang_z : ang_z, {2'b0, ack_q});
				end
			end
			default: f_valid = 1'b0;
		endcase
	end

	logic [OUT_TDATA_W-1:0] o_data_q;
	logic [OUT_TUSER_W-1:0] o_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_v_q <= 1'b0;
		else if (adv)
			o_v_q <= v_q[ST_LAST];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_data_q <= {6'b0, f_rad, sat20(ang_c), st_c[STW-1:0], sat20(lin_c)};
			o_user_q <= {f_mode, f_stop, f_valid};
		end
	end

	assign m_tvalid = o_v_q;
	assign m_tdata  = o_data_q;
	assign m_tuser  = o_user_q;

	// ---------------- assertions ----------------
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_q[ST_LAST] |=> m_tvalid)
		else $error("word at chain end did not reach output");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata[89:0] == '0) && (m_tuser[3:2] == MODE_ACK))
		else $error("stop word carries nonzero command");

	a_reject_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tuser[3:2] == MODE_ACK) && (m_tdata[58:0] == '0))
		else $error("rejected word carries command");

endmodule
`default_nettype wire

// ===== test/velocity_to_steer_mode_command_tb.sv =====
`timescale 1ns / 1ps

module velocity_to_steer_mode_command_tb;
	import v2s_pkg::*;

	// One drive command as the block answers it
	typedef struct {
		bit                valid_res;
		bit                stop;
		logic [1:0]        drive_mode;
		logic [19:0]       linear_cmd;
		logic [18:0]       steering_cmd;
		logic [19:0]       angular_cmd;
		logic [30:0]       curve_radius;
	} drive_cmd_t;

	// Directed row: velocity in, optional hand-typed answer
	typedef struct {
		int         vx;
		int         vy;
		int         wz;
		bit         typed;
		drive_cmd_t ans;
	} vel_row_t;

	localparam int  WATCHDOG_LIMIT = 20000;
	localparam int  SETTLE_CYCLES  = 200;  // well past the depth of the chain
	localparam longint ATAN_TBL [17] = '{51472, 30385, 16055, 8150, 4091, 2047,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // forward_speed[19:0] lateral_speed[39:20] yaw_rate[59:40]
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [95:0] m_tdata;   // linear[19:0] steering[38:20] angular[58:39] radius[89:59]
	logic [3:0]  m_tuser;   // valid_res[0] stop[1] drive_mode[3:2]
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [19:0] cfg_data;

	// Shadow copy of the block's registers
	longint zband, track, axle, rmin, vmax, wmax, crab, ackmax;

	drive_cmd_t cmd_q[$];
	int  send_idle_pct;
	int  recv_stall_pct;
	int  stall_cycles = 0;
	bit  failed = 1'b0;

	velocity_to_steer_mode_command u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic longint lim_mag(longint v, longint m);
		if (v > m)
			return m;
		if (v < -m)
			return -m;
		return v;
	endfunction

	function automatic longint sat_vel(longint v);
		if (v > 524287)
			return 524287;
		if (v < -524288)
			return -524288;
		return v;
	endfunction

	// floor square root, bit by bit
	function automatic bit [63:0] int_root(bit [63:0] n);
		bit [63:0] res;
		bit [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// CORDIC vectoring atan(a/b), a >= 0, b > 0
	function automatic longint atan_q16(bit [63:0] a, bit [63:0] b);
		longint x, y, z, dx, dy;
		z = 0;
		if (a == 0)
			return 0;
		while ((a | b) < (64'd1 << 40)) begin
			a <<= 1;
			b <<= 1;
		end
		x = longint'(b);
		y = longint'(a);
		for (int i = 0; i < 17; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end
		end
		return z;
	endfunction

	function automatic drive_cmd_t steer_predict(logic signed [19:0] fx, logic signed [19:0] fy,
			logic signed [19:0] fw);
		longint vx, vy, wz, ax, ay, aw, lin, steer, ang, rad, d, phi, a, sp;
		bit [63:0] root;
		drive_cmd_t r;
		vx = fx; vy = fy; wz = fw;
		ax = vx < 0 ? -vx : vx;
		ay = vy < 0 ? -vy : vy;
		aw = wz < 0 ? -wz : wz;
		lin = 0; steer = 0; ang = 0; rad = 0;
		r.valid_res = 1'b1;
		r.stop = 1'b0;
		r.drive_mode = MODE_ACK;
		if (ax <= zband && ay <= zband && aw <= zband) begin
			r.stop = 1'b1;
		end else if (ay > zband) begin
			if (ax <= zband && SIDE_SLIP_DEFAULT) begin
				r.drive_mode = MODE_SLIP;
				ang = lim_mag(vy, vmax);
			end else begin
				r.drive_mode = MODE_PAR;
				if (ax <= zband) begin
					steer = vy >= 0 ? crab : -crab;
					lin = lim_mag(vy, vmax);
				end else begin
					a = atan_q16(ay, ax);
					sp = longint'(int_root(ax * ax + ay * ay));
					if ((vx < 0) != (vy < 0))
						a = -a;
					steer = lim_mag(a, crab);
					lin = lim_mag(vx >= 0 ? sp : -sp, vmax);
				end
			end
		end else if (aw <= zband) begin
			lin = lim_mag(vx, vmax);
		end else begin
			rad = (ax << 16) / aw;
			if (rad > 2147483647)
				rad = 2147483647;
			if (rad < rmin) begin
				r.drive_mode = MODE_SPIN;
				ang = lim_mag(wz, wmax);
			end else begin
				root = int_root(rad * rad + ((axle * axle) >> 2));
				d = 2 * longint'(root) - track;
				if (d <= 0) begin
					r.valid_res = 1'b0;   // Ackermann geometry impossible
				end else begin
					phi = atan_q16(axle, d);
					if (((vx < 0) != (wz < 0)) && vx != 0 && rad > 0)
						phi = -phi;
					lin = lim_mag(vx, vmax);
					steer = lim_mag(phi, ackmax);
				end
			end
		end
		r.linear_cmd   = 20'(sat_vel(lin));
		r.steering_cmd = 19'(steer);
		r.angular_cmd  = 20'(sat_vel(ang));
		r.curve_radius = 31'(rad);
		return r;
	endfunction

	// ---------------- configuration ----------------

	task automatic write_reg(logic [2:0] idx, longint val);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_addr = idx;
		cfg_data = 20'(val);
		case (idx)
			REG_ZERO_BAND:    zband  = val & 64'h1FFFF;
			REG_TRACK_WIDTH:  track  = val & 64'hFFFFF;
			REG_AXLE_SPACING: axle   = val & 64'hFFFFF;
			REG_MIN_RADIUS:   rmin   = val & 64'hFFFFF;
			REG_MAX_SPEED:    vmax   = val & 64'hFFFFF;
			REG_MAX_YAW:      wmax   = val & 64'hFFFFF;
			REG_MAX_CRAB:     crab   = val & 64'h3FFFF;
			REG_MAX_ACK:      ackmax = val & 64'h3FFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_regs(longint b, longint t, longint l, longint rm, longint vm,
			longint wm, longint cm, longint am);
		write_reg(REG_ZERO_BAND, b);
		write_reg(REG_TRACK_WIDTH, t);
		write_reg(REG_AXLE_SPACING, l);
		write_reg(REG_MIN_RADIUS, rm);
		write_reg(REG_MAX_SPEED, vm);
		write_reg(REG_MAX_YAW, wm);
		write_reg(REG_MAX_CRAB, cm);
		write_reg(REG_MAX_ACK, am);
	endtask

	// let every outstanding word come back, then let the chain go quiet
	task automatic drain_results();
		while (cmd_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------- stimulus ----------------

	// offer one velocity word; queue the answer once it is taken
	task automatic send_vel(int vx, int vy, int wz, bit typed, drive_cmd_t ans);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {4'b0, 20'(wz), 20'(vy), 20'(vx)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		cmd_q.push_back(typed ? ans : steer_predict(20'(vx), 20'(vy), 20'(wz)));
	endtask

	function automatic int rand_vel();
		return $signed(20'($urandom)) >>> $urandom_range(0, 19);
	endfunction

	function automatic int near_zero();
		return int'($urandom_range(0, 2 * zband)) - int'(zband);
	endfunction

	function automatic int edge_vel();
		case ($urandom_range(0, 5))
			0: return -524288;
			1: return 524287;
			2: return 0;
			3: return int'(zband);
			4: return int'(zband) + 1;
			default: return -int'(zband) - 1;
		endcase
	endfunction

	task automatic send_random();
		int vx, vy, wz;
		drive_cmd_t none;
		none = '{default: 0};
		case ($urandom_range(0, 9))
			0, 1: begin
				vx = $signed(20'($urandom)); vy = $signed(20'($urandom));
				wz = $signed(20'($urandom));
			end
			2: begin vx = near_zero(); vy = near_zero(); wz = near_zero(); end
			3: begin vx = near_zero(); vy = rand_vel(); wz = rand_vel(); end
			4: begin vx = rand_vel(); vy = near_zero(); wz = near_zero(); end
			5: begin
				// small forward, large yaw: spin territory
				vx = int'($urandom_range(0, 4000)) - 2000; vy = near_zero();
				wz = $signed(20'($urandom));
			end
			6, 7: begin vx = rand_vel(); vy = near_zero(); wz = rand_vel(); end
			8: begin vx = rand_vel(); vy = rand_vel(); wz = rand_vel(); end
			default: begin vx = edge_vel(); vy = edge_vel(); wz = edge_vel(); end
		endcase
		send_vel(vx, vy, wz, 1'b0, none);
	endtask

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		drive_cmd_t want;
		if (m_tvalid && m_tready) begin
			if (cmd_q.size() == 0) begin
				$error("unexpected word: tuser %h tdata %h", m_tuser, m_tdata);
				failed = 1'b1;
			end else begin
				want = cmd_q.pop_front();
				if (m_tuser[0] !== want.valid_res) begin
					$error("valid_res: expected %0d got %0d", want.valid_res, m_tuser[0]);
					failed = 1'b1;
				end
				if (m_tuser[1] !== want.stop) begin
					$error("stop: expected %0d got %0d", want.stop, m_tuser[1]);
					failed = 1'b1;
				end
				if (m_tuser[3:2] !== want.drive_mode) begin
					$error("drive_mode: expected %0d got %0d", want.drive_mode,
						m_tuser[3:2]);
					failed = 1'b1;
				end
				if (m_tdata[19:0] !== want.linear_cmd) begin
					$error("linear_cmd: expected %0d got %0d", $signed(want.linear_cmd),
						$signed(m_tdata[19:0]));
					failed = 1'b1;
				end
				if (m_tdata[38:20] !== want.steering_cmd) begin
					$error("steering_cmd: expected %0d got %0d",
						$signed(want.steering_cmd), $signed(m_tdata[38:20]));
					failed = 1'b1;
				end
				if (m_tdata[58:39] !== want.angular_cmd) begin
					$error("angular_cmd: expected %0d got %0d", $signed(want.angular_cmd),
						$signed(m_tdata[58:39]));
					failed = 1'b1;
				end
				if (m_tdata[89:59] !== want.curve_radius) begin
					$error("curve_radius: expected %0d got %0d", want.curve_radius,
						m_tdata[89:59]);
					failed = 1'b1;
				end
			end
		end
	end

	// downstream backpressure
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// no handshake on either side for too long: give up
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("velocity_to_steer_mode_command_tb: errors");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	function automatic drive_cmd_t typed_cmd(bit v, bit st, logic [1:0] md, int lin, int ang,
			int rad);
		drive_cmd_t r;
		r = '{default: 0};
		r.valid_res = v;
		r.stop = st;
		r.drive_mode = md;
		r.linear_cmd = 20'(lin);
		r.angular_cmd = 20'(ang);
		r.curve_radius = 31'(rad);
		return r;
	endfunction

	initial begin
		vel_row_t rows[$];
		drive_cmd_t none;
		none = '{default: 0};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		zband = 66; track = 26214; axle = 32768; rmin = 32768;
		vmax = 98304; wmax = 65536; crab = 45747; ackmax = 45747;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words under reset register values
		rows = '{
			'{0, 0, 0, 1, typed_cmd(1, 1, MODE_ACK, 0, 0, 0)},
			'{66, -66, 66, 1, typed_cmd(1, 1, MODE_ACK, 0, 0, 0)},
			'{0, 524287, 0, 1, typed_cmd(1, 0, MODE_SLIP, 0, 98304, 0)},
			'{0, -524288, 0, 1, typed_cmd(1, 0, MODE_SLIP, 0, -98304, 0)},
			'{524287, 0, 0, 1, typed_cmd(1, 0, MODE_ACK, 98304, 0, 0)},
			'{-524288, 0, 0, 1, typed_cmd(1, 0, MODE_ACK, -98304, 0, 0)},
			'{67, 0, 0, 1, typed_cmd(1, 0, MODE_ACK, 67, 0, 0)},
			'{0, 0, 524287, 1, typed_cmd(1, 0, MODE_SPIN, 0, 65536, 0)},
			'{0, 0, -524288, 1, typed_cmd(1, 0, MODE_SPIN, 0, -65536, 0)},
			'{65536, 65536, 0, 0, none},
			'{-65536, 30000, 0, 0, none},
			'{100, -524288, 5, 0, none},
			'{-524288, 524287, 0, 0, none},
			'{65536, 0, 65536, 0, none},
			'{-65536, 0, 65536, 0, none},
			'{65536, 0, -524288, 0, none},
			'{524287, 0, 67, 0, none},
			'{-524288, 66, -67, 0, none},
			'{524287, 524287, 524287, 0, none},
			'{-524288, -524288, -524288, 0, none}
		};
		foreach (rows[i])
			send_vel(rows[i].vx, rows[i].vy, rows[i].wz, rows[i].typed, rows[i].ans);

		// random phases, each with its own register set and handshake pressure
		for (int ph = 0; ph < 7; ph++) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			drain_results();
			case (ph)
				0: load_regs(66, 26214, 32768, 32768, 98304, 65536, 45747, 45747);
				1: load_regs(65536, 524288, 524288, 524288, 524288, 524288, 205887, 205887);
				2: load_regs(0, 0, 0, 0, 0, 0, 0, 0);
				// wide track, short wheelbase, no spin: rejected curves show up
				3: load_regs(66, 524288, 8192, 0, 300000, 200000, 100000, 100000);
				default: load_regs($urandom_range(0, 65536), $urandom_range(0, 524288),
					$urandom_range(0, 524288), $urandom_range(0, 524288),
					$urandom_range(0, 524288), $urandom_range(0, 524288),
					$urandom_range(0, 205887), $urandom_range(0, 205887));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 53; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 53; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			for (int n = 0; n < 215; n++) begin
				// hold the input back once until the output side is empty
				if (ph == 4 && n == 100) begin
					@(negedge clk);
					s_tvalid = 1'b0;
					while (cmd_q.size() != 0)
						@(posedge clk);
				end
				send_random();
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;
		drain_results();

		if (!failed && cmd_q.size() == 0)
			$display("velocity_to_steer_mode_command_tb: clean");
		else
			$display("velocity_to_steer_mode_command_tb: errors");
		$finish;
	end

endmodule
